@@ hw/rtl/tdsq_pkg.sv @@
package tdsq_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int COORD_W         = 32;
  localparam int HANDLE_W        = 16;
  localparam int KEY_W           = 32;
  localparam int CFG_IDX_W       = 2;

  // Product of two Q16.16 values is Q32.32; after the floor shift it keeps 48 bits.
  localparam int PROD_W  = 2 * COORD_W;
  localparam int SHIFT_W = PROD_W - 16;
  // Three shifted products plus the offset, summed exactly.
  localparam int SUM_W   = SHIFT_W + 3;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_FLUSH  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIEW_X      = 2'd0,
    CFG_VIEW_Y      = 2'd1,
    CFG_VIEW_Z      = 2'd2,
    CFG_VIEW_OFFSET = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] min_z;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] max_y;
    logic [COORD_W-1:0] max_z;
  } box_t;

  typedef struct packed {
    logic [COORD_W-1:0] col_x;
    logic [COORD_W-1:0] col_y;
    logic [COORD_W-1:0] col_z;
    logic [COORD_W-1:0] offset;
  } view_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] frame;
    logic [HANDLE_W-1:0] pkg;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic rot;
  } row_ctl_t;

endpackage

@@ hw/rtl/translucent_depth_sort_queue.sv @@
// Back-to-front sorted queue for translucent objects. Each input word is a clear, an
// insert or a flush. An insert carries a bounding box in Q16.16 and two 16-bit
// handles; its key is the largest view-space depth of the eight box corners, taken
// with the depth column written through the configuration port, with floor rounding
// of each product and saturation of the sum to 32 bits. Entries are held in
// descending key order, and equal keys keep the order in which they arrived. A flush
// sends out every held entry, largest key first, one word per cycle while the output
// is not stalled, marks the final word with out_last and does not empty the queue;
// out_overflow reports that an insert was dropped because the queue was full since
// the last clear. Once accepted, an insert holds in_stall high while the six corner
// products go one by one through the single shared 32x32 multiplier, followed by the
// per-axis maximum, the sum, the saturation and the parallel insert into the sorted
// row of cells. A flush holds the input until its final word is loaded, and longer
// while the output is stalled. A clear, an insert into a full queue, a flush of an
// empty queue and the unused kind do not raise in_stall. Configuration must be
// written only while the block is idle; the block does not enforce it.
module translucent_depth_sort_queue #(
  parameter int QUEUE_DEPTH = tdsq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              cfg_we,
  input  logic [tdsq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_wdata,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_kind,
  input  logic signed [31:0]                in_min_x,
  input  logic signed [31:0]                in_min_y,
  input  logic signed [31:0]                in_min_z,
  input  logic signed [31:0]                in_max_x,
  input  logic signed [31:0]                in_max_y,
  input  logic signed [31:0]                in_max_z,
  input  logic [15:0]                       in_frame_handle,
  input  logic [15:0]                       in_package_handle,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [31:0]                out_depth_key,
  output logic [15:0]                       out_frame,
  output logic [15:0]                       out_package,
  output logic                              out_last,
  output logic                              out_overflow
);
  import tdsq_pkg::*;

  localparam int               CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL  = CNT_W'(QUEUE_DEPTH);

  // Configuration: the view-matrix depth column.
  view_t view_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_VIEW_X:      view_r.col_x  <= cfg_wdata;
        CFG_VIEW_Y:      view_r.col_y  <= cfg_wdata;
        CFG_VIEW_Z:      view_r.col_z  <= cfg_wdata;
        CFG_VIEW_OFFSET: view_r.offset <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Control state.
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] emit_r, emit_nxt;
  logic             dropped_r, dropped_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload held for the insert in flight and the output word.
  logic [15:0]      frame_r, pkg_r;
  entry_t           out_entry_r;
  logic             out_last_r, out_ovf_r;

  logic             accept;
  logic             start;
  logic             load_out;
  logic             last_emit;
  logic             key_done;
  logic [KEY_W-1:0] key;
  box_t             box;
  entry_t           new_entry;
  entry_t           head;
  row_ctl_t         row_ctl;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign load_out  = (state_r == ST_FLUSH) && (!out_valid_r || !out_stall);
  assign last_emit = (emit_r == count_r - CNT_W'(1));

  assign box = '{min_x: in_min_x, min_y: in_min_y, min_z: in_min_z,
                 max_x: in_max_x, max_y: in_max_y, max_z: in_max_z};

  assign new_entry = '{key: key, frame: frame_r, pkg: pkg_r};

  // The shared multiplier and its sequencer.
  tdsq_depth_unit u_depth (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (start),
    .box_i   (box),
    .view_i  (view_r),
    .done_o  (key_done),
    .key_o   (key)
  );

  // The sorted row of cells.
  tdsq_sort_row #(
    .DEPTH (QUEUE_DEPTH),
    .CNT_W (CNT_W)
  ) u_row (
    .clk     (clk),
    .ctl_i   (row_ctl),
    .count_i (count_r),
    .new_i   (new_entry),
    .head_o  (head)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    emit_nxt      = emit_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r && out_stall;
    start         = 1'b0;
    row_ctl       = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (kind_t'(in_kind))
            KIND_CLEAR: begin
              count_nxt   = '0;
              dropped_nxt = 1'b0;
            end
            KIND_INSERT: begin
              // A full queue drops the insert at once; no key is needed for that.
              if (count_r == FULL) begin
                dropped_nxt = 1'b1;
              end else begin
                start     = 1'b1;
                state_nxt = ST_KEY;
              end
            end
            KIND_FLUSH: begin
              if (count_r != '0) begin
                emit_nxt  = '0;
                state_nxt = ST_FLUSH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_KEY: begin
        if (key_done) begin
          row_ctl.ins = 1'b1;
          count_nxt   = count_r + CNT_W'(1);
          state_nxt   = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        // Each word taken from the head turns the ring one place, so after the last
        // word the row is back in its original order.
        if (load_out) begin
          out_valid_nxt = 1'b1;
          row_ctl.rot   = 1'b1;
          emit_nxt      = emit_r + CNT_W'(1);
          if (last_emit) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      emit_r      <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      emit_r      <= emit_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      frame_r <= in_frame_handle;
      pkg_r   <= in_package_handle;
    end
    if (load_out) begin
      out_entry_r <= head;
      out_last_r  <= last_emit;
      out_ovf_r   <= dropped_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_depth_key = out_entry_r.key;
  assign out_frame     = out_entry_r.frame;
  assign out_package   = out_entry_r.pkg;
  assign out_last      = out_last_r;
  assign out_overflow  = out_ovf_r;

  // The fill count never runs past the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("fill count exceeds queue depth");

  // A finished key only ever arrives while an insert is waiting for it.
  a_key_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    key_done |-> state_r == ST_KEY)
    else $error("depth unit finished outside an insert");

  // A clear empties the queue and drops the overflow flag.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == KIND_CLEAR) |=> (count_r == '0 && !dropped_r))
    else $error("clear did not empty the queue");

  // An insert that is not dropped adds exactly one entry.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_KEY && key_done) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not add one entry");

endmodule

@@ hw/rtl/tdsq_depth_unit.sv @@
module tdsq_depth_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  tdsq_pkg::box_t              box_i,
  input  tdsq_pkg::view_t             view_i,
  output logic                        done_o,
  output logic [tdsq_pkg::KEY_W-1:0]  key_o
);
  import tdsq_pkg::*;

  localparam logic [2:0] LAST_MUL = 3'd5;
  localparam logic [2:0] SAT_STEP = 3'd7;

  // Depth is linear per axis, so the deepest corner takes the larger product on each
  // axis; saturation is monotonic and is applied once at the end.
  box_t                      box_r;
  logic                      busy_r;
  logic [2:0]                step_r;
  logic [2:0]                step_prev;
  logic                      done_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [SHIFT_W-1:0] amax_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic [KEY_W-1:0]          key_r;

  logic signed [COORD_W-1:0] coord;
  logic signed [COORD_W-1:0] col;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [SHIFT_W-1:0] shifted;
  logic signed [SHIFT_W-1:0] axis_max;
  logic [KEY_W-1:0]          sat_key;

  always_comb begin
    case (step_r)
      3'd0:    coord = box_r.min_x;
      3'd1:    coord = box_r.max_x;
      3'd2:    coord = box_r.min_y;
      3'd3:    coord = box_r.max_y;
      3'd4:    coord = box_r.min_z;
      default: coord = box_r.max_z;
    endcase
    case (step_r[2:1])
      2'd0:    col = view_i.col_x;
      2'd1:    col = view_i.col_y;
      default: col = view_i.col_z;
    endcase
  end

  assign prod_nxt  = PROD_W'(coord) * PROD_W'(col);
  assign shifted   = prod_r[PROD_W-1:16];
  assign axis_max  = (shifted > amax_r) ? shifted : amax_r;
  assign step_prev = step_r - 3'd1;

  always_comb begin
    if (sum_r > SUM_W'(signed'({1'b0, {(KEY_W-1){1'b1}}}))) begin
      sat_key = {1'b0, {(KEY_W-1){1'b1}}};
    end else if (sum_r < -SUM_W'(signed'({1'b0, 1'b1, {(KEY_W-1){1'b0}}}))) begin
      sat_key = {1'b1, {(KEY_W-1){1'b0}}};
    end else begin
      sat_key = sum_r[KEY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 3'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        step_r <= 3'd0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == SAT_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      box_r <= box_i;
      sum_r <= SUM_W'(signed'(view_i.offset));
    end else if (busy_r) begin
      if (step_r <= LAST_MUL) begin
        prod_r <= prod_nxt;
      end
      if (step_r != 3'd0 && step_r != SAT_STEP) begin
        if (!step_prev[0]) begin
          amax_r <= shifted;
        end else begin
          sum_r <= sum_r + SUM_W'(axis_max);
        end
      end
      if (step_r == SAT_STEP) begin
        key_r <= sat_key;
      end
    end
  end

  assign done_o = done_r;
  assign key_o  = key_r;

endmodule

@@ hw/rtl/tdsq_sort_row.sv @@
module tdsq_sort_row #(
  parameter int DEPTH = tdsq_pkg::QUEUE_DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  tdsq_pkg::row_ctl_t   ctl_i,
  input  logic [CNT_W-1:0]     count_i,
  input  tdsq_pkg::entry_t     new_i,
  output tdsq_pkg::entry_t     head_o
);
  import tdsq_pkg::*;

  entry_t cell_r [DEPTH];
  logic   stays  [DEPTH];

  // A cell keeps its entry when it is filled and its key is not below the new key;
  // in a descending row these cells form a prefix, so equal keys stay ahead.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX  = CNT_W'(i);
    localparam logic [CNT_W-1:0] NEXT = CNT_W'(i + 1);

    entry_t ins_val;
    entry_t rot_val;

    assign stays[i] = (IDX < count_i) && ($signed(cell_r[i].key) >= $signed(new_i.key));

    if (i == 0) begin : g_first
      assign ins_val = stays[i] ? cell_r[i] : new_i;
    end else begin : g_rest
      assign ins_val = stays[i] ? cell_r[i] : (stays[i-1] ? new_i : cell_r[i-1]);
    end

    // During a flush the filled part of the row turns as a ring towards cell zero.
    if (i == DEPTH - 1) begin : g_tail
      assign rot_val = (NEXT == count_i) ? cell_r[0] : cell_r[i];
    end else begin : g_body
      assign rot_val = (NEXT == count_i) ? cell_r[0] : cell_r[i+1];
    end

    always_ff @(posedge clk) begin
      if (ctl_i.ins) begin
        cell_r[i] <= ins_val;
      end else if (ctl_i.rot) begin
        cell_r[i] <= rot_val;
      end
    end
  end

  assign head_o = cell_r[0];

endmodule
